// ===== hw/rtl/usp_pkg.sv =====
// ----------------------------------------------------------------------------
// usp_pkg
// Shared types, constants and helpers for the UTF-16 sanitizing stream.
// ----------------------------------------------------------------------------
package usp_pkg;

  localparam int UNIT_W    = 16;
  localparam int CHAR_W    = 21;
  localparam int COUNT_W   = 17;
  localparam int MAX_UNITS = 4;
  localparam int NUM_W     = $clog2(MAX_UNITS + 1);
  localparam int PTR_W     = $clog2(MAX_UNITS);

  localparam logic [COUNT_W-1:0] COUNT_CAP        = 17'd65536;
  localparam logic [CHAR_W-1:0]  DEFAULT_CHAR_RST = 21'd65533;
  localparam logic [CHAR_W-1:0]  SUBST_CHAR       = 21'h00FFFD;
  localparam logic [CHAR_W-1:0]  MAX_SCALAR       = 21'h10FFFF;
  localparam logic [CHAR_W-1:0]  SUPP_BASE        = 21'h010000;
  localparam logic [UNIT_W-1:0]  HIGH_BASE        = 16'hD800;
  localparam logic [UNIT_W-1:0]  LOW_BASE         = 16'hDC00;

  localparam logic [0:0] REG_DEFAULT_CHAR = 1'b0;
  localparam logic [0:0] REG_SWAP_BYTES   = 1'b1;

  typedef struct packed {
    logic [UNIT_W-1:0]  unit;
    logic               rep;
    logic [COUNT_W-1:0] chars;
    logic [COUNT_W-1:0] invalid;
  } entry_t;

  typedef struct packed {
    entry_t [MAX_UNITS-1:0] ent;
    logic [NUM_W-1:0]       count;
  } group_t;

  typedef struct packed {
    logic               pending_valid;
    logic [UNIT_W-1:0]  pending_high;
    logic [COUNT_W-1:0] char_counter;
    logic [COUNT_W-1:0] invalid_counter;
  } state_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v >= COUNT_CAP) ? COUNT_CAP : v + COUNT_W'(1);
  endfunction

  function automatic logic is_high_sur(input logic [UNIT_W-1:0] u);
    return u[15:10] == 6'b110110;
  endfunction

  function automatic logic is_low_sur(input logic [UNIT_W-1:0] u);
    return u[15:10] == 6'b110111;
  endfunction

endpackage

// ===== hw/rtl/usp_build.sv =====
// ----------------------------------------------------------------------------
// usp_build
// Builds the group of output units for one code unit and the next state.
// ----------------------------------------------------------------------------
module usp_build (
  input  logic [usp_pkg::UNIT_W-1:0] unit,
  input  logic                       last,
  input  logic [usp_pkg::CHAR_W-1:0] default_char,
  input  usp_pkg::state_t            cur,
  output usp_pkg::group_t            grp,
  output usp_pkg::state_t            nxt
);

  logic [usp_pkg::CHAR_W-1:0]  rep_c;
  logic [usp_pkg::CHAR_W-1:0]  rep_v;
  logic                        rep_two;
  logic [usp_pkg::UNIT_W-1:0]  rep_first;
  logic [usp_pkg::UNIT_W-1:0]  rep_second;

  always_comb begin
    if (default_char > usp_pkg::MAX_SCALAR ||
        (default_char[20:11] == 10'b0000011011)) begin
      rep_c = usp_pkg::SUBST_CHAR;
    end else begin
      rep_c = default_char;
    end
    rep_v      = rep_c - usp_pkg::SUPP_BASE;
    rep_two    = rep_c[20:16] != 5'd0;
    rep_first  = rep_two ? (usp_pkg::HIGH_BASE | {6'd0, rep_v[19:10]}) : rep_c[15:0];
    rep_second = usp_pkg::LOW_BASE | {6'd0, rep_c[9:0]};
  end

  always_comb begin
    logic                       hi;
    logic                       lo;
    logic [usp_pkg::NUM_W-1:0]  n;
    logic [usp_pkg::COUNT_W-1:0] c;
    logic [usp_pkg::COUNT_W-1:0] i;
    hi  = usp_pkg::is_high_sur(unit);
    lo  = usp_pkg::is_low_sur(unit);
    n   = '0;
    c   = cur.char_counter;
    i   = cur.invalid_counter;
    grp = '0;
    nxt = cur;
    if (cur.pending_valid && lo) begin
      c = usp_pkg::sat_inc(c);
      grp.ent[0] = '{cur.pending_high, 1'b0, c, i};
      grp.ent[1] = '{unit, 1'b0, c, i};
      n = usp_pkg::NUM_W'(2);
      nxt.pending_valid = 1'b0;
    end else begin
      if (cur.pending_valid) begin
        nxt.pending_valid = 1'b0;
        c = usp_pkg::sat_inc(c);
        i = usp_pkg::sat_inc(i);
        grp.ent[n[usp_pkg::PTR_W-1:0]] = '{rep_first, 1'b1, c, i};
        n = n + usp_pkg::NUM_W'(1);
        if (rep_two) begin
          grp.ent[n[usp_pkg::PTR_W-1:0]] = '{rep_second, 1'b1, c, i};
          n = n + usp_pkg::NUM_W'(1);
        end
      end
      if (hi && !last) begin
        nxt.pending_valid = 1'b1;
        nxt.pending_high  = unit;
      end else if (hi || lo) begin
        c = usp_pkg::sat_inc(c);
        i = usp_pkg::sat_inc(i);
        grp.ent[n[usp_pkg::PTR_W-1:0]] = '{rep_first, 1'b1, c, i};
        n = n + usp_pkg::NUM_W'(1);
        if (rep_two) begin
          grp.ent[n[usp_pkg::PTR_W-1:0]] = '{rep_second, 1'b1, c, i};
          n = n + usp_pkg::NUM_W'(1);
        end
      end else begin
        c = usp_pkg::sat_inc(c);
        grp.ent[n[usp_pkg::PTR_W-1:0]] = '{unit, 1'b0, c, i};
        n = n + usp_pkg::NUM_W'(1);
      end
    end
    grp.count           = n;
    nxt.char_counter    = c;
    nxt.invalid_counter = i;
    if (last) begin
      nxt = '0;
    end
  end

endmodule

// ===== hw/rtl/utf16_sanitize_stream.sv =====
// ----------------------------------------------------------------------------
// utf16_sanitize_stream
// UTF-16 validator: pairs surrogates and replaces bad units with default_char.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  in       in   in_valid/in_stall  code_unit, last_unit
//  out      out  out_valid/out_stall out_unit, is_replacement, run_end,
//                                   text_end, chars_seen, invalid_seen
//  cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
//  One beat per cycle in unless stalled; each input unit yields 0 to 4 output
//  beats, one per cycle unless out_stall, via the input and group registers.
//  Input stalls while the input register is full and the output group is not
//  finishing: a group of two or more beats still draining, or an output stall.
//  Reset clears held surrogate, counters, and loads default registers.
// ----------------------------------------------------------------------------
module utf16_sanitize_stream (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [usp_pkg::UNIT_W-1:0]  code_unit,
  input  logic                        last_unit,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [usp_pkg::UNIT_W-1:0]  out_unit,
  output logic                        is_replacement,
  output logic                        run_end,
  output logic                        text_end,
  output logic [usp_pkg::COUNT_W-1:0] chars_seen,
  output logic [usp_pkg::COUNT_W-1:0] invalid_seen,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [0:0]                  cfg_index,
  input  logic [usp_pkg::CHAR_W-1:0]  cfg_data
);

  logic [usp_pkg::CHAR_W-1:0] default_char;
  logic                       swap_bytes;

  logic                       a_valid;
  logic [usp_pkg::UNIT_W-1:0] a_unit;
  logic                       a_last;

  logic                       b_valid;
  logic                       b_last;
  usp_pkg::group_t            b_grp;
  logic [usp_pkg::PTR_W-1:0]  ptr;

  usp_pkg::state_t            st;
  usp_pkg::state_t            st_next;
  usp_pkg::group_t            grp_next;
  logic [usp_pkg::UNIT_W-1:0] unit_sw;

  logic                       take;
  logic                       b_done;
  logic                       a_move;
  logic                       b_is_last;
  usp_pkg::entry_t            cur_ent;

  assign cfg_ready = 1'b1;
  assign unit_sw   = swap_bytes ? {a_unit[7:0], a_unit[15:8]} : a_unit;

  usp_build u_build (
    .unit         (unit_sw),
    .last         (a_last),
    .default_char (default_char),
    .cur          (st),
    .grp          (grp_next),
    .nxt          (st_next)
  );

  assign b_is_last = {1'b0, ptr} == (b_grp.count - usp_pkg::NUM_W'(1));
  assign take      = out_valid && !out_stall;
  assign b_done    = take && b_is_last;
  assign a_move    = a_valid && (!b_valid || b_done);
  assign in_stall  = a_valid && !a_move;

  assign cur_ent        = b_grp.ent[ptr];
  assign out_valid      = b_valid;
  assign out_unit       = cur_ent.unit;
  assign is_replacement = cur_ent.rep;
  assign chars_seen     = cur_ent.chars;
  assign invalid_seen   = cur_ent.invalid;
  assign run_end        = b_is_last;
  assign text_end       = b_is_last && b_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_char <= usp_pkg::DEFAULT_CHAR_RST;
      swap_bytes   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        usp_pkg::REG_DEFAULT_CHAR: default_char <= cfg_data;
        usp_pkg::REG_SWAP_BYTES:   swap_bytes   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      a_unit <= code_unit;
      a_last <= last_unit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= '0;
      b_valid <= 1'b0;
      ptr     <= '0;
    end else begin
      if (a_move) begin
        st      <= st_next;
        b_valid <= grp_next.count != '0;
        ptr     <= '0;
      end else if (b_done) begin
        b_valid <= 1'b0;
        ptr     <= '0;
      end else if (take) begin
        ptr <= ptr + usp_pkg::PTR_W'(1);
      end
    end
    if (a_move) begin
      b_grp  <= grp_next;
      b_last <= a_last;
    end
  end

  a_grp_count: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (b_grp.count != '0 && {1'b0, ptr} < b_grp.count))
    else $error("output group pointer out of range");

  a_text_clear: assert property (@(posedge clk) disable iff (rst)
    (a_move && a_last) |=> (!st.pending_valid && st.char_counter == '0 &&
                            st.invalid_counter == '0))
    else $error("state not cleared at end of text");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    st.char_counter <= usp_pkg::COUNT_CAP && st.invalid_counter <= st.char_counter)
    else $error("counter beyond cap");

  a_no_move_busy: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_done) |-> !a_move)
    else $error("group overwritten before drained");

endmodule
